// ----- rtl/ddr_pkg.sv -----
package ddr_pkg;

  localparam int LOCAL_W   = 8;
  localparam int INDEX_W   = 6;
  localparam int LEVEL_W   = 7;
  localparam int DEP_W     = 64;
  localparam int SRC_SLOTS = 4;
  localparam int DST_SLOTS = 2;

  // per-beat control handed from the top level to each lane
  typedef struct packed {
    logic adv;      // whole pipeline moves one stage
    logic src_ok;   // this lane's input local has a live writer
    logic src_sel;  // writer bank that holds the newest write of that local
    logic fwd_en;   // the stage ahead holds a real instruction
    logic dep_we;   // that instruction writes its row this cycle
  } lane_ctl_t;

endpackage

// ----- rtl/ddr_if.sv -----
interface ddr_in_if;
  logic                       valid;
  logic                       ready;
  logic                       first_of_function;
  logic [ddr_pkg::LOCAL_W-1:0] src_local_a;
  logic [ddr_pkg::LOCAL_W-1:0] src_local_b;
  logic [ddr_pkg::LOCAL_W-1:0] src_local_c;
  logic [ddr_pkg::LOCAL_W-1:0] src_local_d;
  logic [3:0]                 src_valid;
  logic [ddr_pkg::LOCAL_W-1:0] dst_local_a;
  logic [ddr_pkg::LOCAL_W-1:0] dst_local_b;
  logic [1:0]                 dst_valid;

  modport source (
    output valid, first_of_function, src_local_a, src_local_b, src_local_c, src_local_d,
           src_valid, dst_local_a, dst_local_b, dst_valid,
    input  ready
  );
  modport sink (
    input  valid, first_of_function, src_local_a, src_local_b, src_local_c, src_local_d,
           src_valid, dst_local_a, dst_local_b, dst_valid,
    output ready
  );
endinterface

interface ddr_out_if;
  logic                        valid;
  logic                        ready;
  logic [ddr_pkg::INDEX_W-1:0] instr_index;
  logic [ddr_pkg::LEVEL_W-1:0] level;
  logic [ddr_pkg::DEP_W-1:0]   depends_on;
  logic                        overflow;

  modport source (
    output valid, instr_index, level, depends_on, overflow,
    input  ready
  );
  modport sink (
    input  valid, instr_index, level, depends_on, overflow,
    output ready
  );
endinterface

// ----- rtl/ddr_lane.sv -----
module ddr_lane #(
  parameter int MAX_INSTR  = 64,
  parameter int MAX_LOCALS = 256,
  parameter int MAX_DST    = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ddr_pkg::lane_ctl_t                 ctl_i,
  input  logic [$clog2(MAX_LOCALS)-1:0]      src_addr_i,
  input  logic [MAX_DST-1:0]                 wr_en_i,
  input  logic [$clog2(MAX_LOCALS)-1:0]      wr_addr_i [MAX_DST],
  input  logic [$clog2(MAX_INSTR)-1:0]       wr_idx_i,
  input  logic [$clog2(MAX_INSTR)-1:0]       dep_addr_i,
  input  logic [MAX_INSTR-1:0]               dep_row_i,
  input  logic [ddr_pkg::LEVEL_W-1:0]        dep_rank_i,
  input  logic [$clog2(MAX_INSTR)-1:0]       fwd_idx_i,
  input  logic [MAX_INSTR-1:0]               fwd_row_i,
  input  logic [ddr_pkg::LEVEL_W-1:0]        fwd_rank_i,
  output logic [MAX_INSTR-1:0]               row_o,
  output logic [ddr_pkg::LEVEL_W-1:0]        rank_o
);
  import ddr_pkg::*;

  localparam int IDXW = $clog2(MAX_INSTR);
  localparam int DW   = MAX_INSTR + LEVEL_W;

  logic [IDXW-1:0] bank_rd [MAX_DST];
  logic [IDXW-1:0] w1;
  logic            ok1_q, ok2_q, hit2_q, sel1_q;
  logic [IDXW-1:0] w2_q;
  logic [DW-1:0]   dep_rd_q;
  logic [DW-1:0]   dep_mem [MAX_INSTR];
  logic [MAX_INSTR-1:0]  src_row;
  logic [LEVEL_W-1:0]    src_rank;

  // one writer bank per output slot, read through this lane's port
  for (genvar b = 0; b < MAX_DST; b++) begin : g_bank
    logic [IDXW-1:0] mem [MAX_LOCALS];
    logic [IDXW-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        rd_q <= mem[src_addr_i];
      end
      if (wr_en_i[b]) begin
        mem[wr_addr_i[b]] <= wr_idx_i;
      end
    end
    assign bank_rd[b] = rd_q;
  end

  assign w1 = (MAX_DST > 1 && sel1_q) ? bank_rd[MAX_DST-1] : bank_rd[0];

  // private copy of the dependency rows and ranks
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      dep_rd_q <= dep_mem[w1];
    end
    if (ctl_i.dep_we) begin
      dep_mem[dep_addr_i] <= {dep_row_i, dep_rank_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok1_q  <= 1'b0;
      ok2_q  <= 1'b0;
      hit2_q <= 1'b0;
    end else if (ctl_i.adv) begin
      ok1_q  <= ctl_i.src_ok;
      ok2_q  <= ok1_q;
      // producer row is being written on this very edge, take it from the output stage
      hit2_q <= ctl_i.fwd_en && (w1 == fwd_idx_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      sel1_q <= ctl_i.src_sel;
      w2_q   <= w1;
    end
  end

  assign src_row  = hit2_q ? fwd_row_i  : dep_rd_q[DW-1:LEVEL_W];
  assign src_rank = hit2_q ? fwd_rank_i : dep_rd_q[LEVEL_W-1:0];

  assign row_o  = ok2_q ? ((MAX_INSTR'(1) << w2_q) | src_row) : '0;
  assign rank_o = ok2_q ? src_rank : '0;

endmodule

// ----- rtl/ddr_merge.sv -----
module ddr_merge #(
  parameter int MAX_INSTR = 64,
  parameter int MAX_SRC   = 4
) (
  input  logic [MAX_INSTR-1:0]        row_i  [MAX_SRC],
  input  logic [ddr_pkg::LEVEL_W-1:0] rank_i [MAX_SRC],
  output logic [MAX_INSTR-1:0]        row_o,
  output logic [ddr_pkg::LEVEL_W-1:0] level_o
);
  import ddr_pkg::*;

  logic [LEVEL_W-1:0] best;

  always_comb begin
    row_o = '0;
    best  = '0;
    for (int l = 0; l < MAX_SRC; l++) begin
      row_o = row_o | row_i[l];
      if (rank_i[l] > best) begin
        best = rank_i[l];
      end
    end
    level_o = best + LEVEL_W'(1);
  end

endmodule

// ----- rtl/dataflow_dependency_ranker_top.sv -----
// Dependency level scheduler for a stream of dataflow instructions.
//
// in_i carries one instruction per beat: up to four input locals and two
// output locals under valid masks, plus a first-of-function flag. out_o
// returns one beat per instruction, in order: its index in the function,
// its level, its transitive dependency row and an overflow flag. Beats past
// capacity come back with overflow set and all other fields zero.
//
// Throughput is one instruction per cycle while the receiver does not stall.
// Every source slot has its own lane with a private copy of the writer table
// (one bank per output slot, single read port each) and of the row/rank store;
// a row still being written by the instruction just ahead is forwarded from the
// output register. Results pass the lane read stages and the output register.
//
// Reset clears the instruction counter and the writer valid bits; the table
// memories are not cleared. When the receiver stalls, the whole pipeline
// holds and in_i.ready drops until the output beat is taken.
module dataflow_dependency_ranker_top #(
  parameter int MAX_INSTR  = 64,
  parameter int MAX_LOCALS = 256,
  parameter int MAX_SRC    = 4,
  parameter int MAX_DST    = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ddr_in_if.sink   in_i,
  ddr_out_if.source out_o
);
  import ddr_pkg::*;

  localparam int LW   = $clog2(MAX_LOCALS);
  localparam int IDXW = $clog2(MAX_INSTR);
  localparam int CW   = $clog2(MAX_INSTR + 1);

  logic               adv, acc, live, fof, ovf0;
  logic [CW-1:0]      base, cnt_q, cnt_d;
  logic [IDXW-1:0]    idx0;
  logic [LOCAL_W-1:0] src [SRC_SLOTS];
  logic [LOCAL_W-1:0] dst [DST_SLOTS];

  logic [MAX_LOCALS-1:0] vld_q, vld_d, sel_q, sel_d;
  logic [MAX_DST-1:0]    wr_en;
  logic [LW-1:0]         wr_addr [MAX_DST];

  logic                  v1_q, ovf1_q, v2_q, ovf2_q;
  logic [IDXW-1:0]       idx1_q, idx2_q;
  logic                  out_valid_q, ovf_q;
  logic [IDXW-1:0]       idx_q;
  logic [LEVEL_W-1:0]    level_q, level_m;
  logic [MAX_INSTR-1:0]  row_q, row_m;
  logic                  fwd_en, dep_we;

  logic [MAX_INSTR-1:0]  lane_row  [MAX_SRC];
  logic [LEVEL_W-1:0]    lane_rank [MAX_SRC];

  assign src[0] = in_i.src_local_a;
  assign src[1] = in_i.src_local_b;
  assign src[2] = in_i.src_local_c;
  assign src[3] = in_i.src_local_d;
  assign dst[0] = in_i.dst_local_a;
  assign dst[1] = in_i.dst_local_b;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;
  assign acc        = in_i.valid && adv;
  assign fof        = in_i.first_of_function;
  assign base       = fof ? '0 : cnt_q;
  assign ovf0       = base >= CW'(MAX_INSTR);
  assign idx0       = base[IDXW-1:0];
  assign live       = acc && !ovf0;
  assign cnt_d      = live ? base + CW'(1) : cnt_q;

  for (genvar k = 0; k < MAX_DST; k++) begin : g_dst
    assign wr_addr[k] = LW'(dst[k]);
    assign wr_en[k]   = live && in_i.dst_valid[k] && (32'(dst[k]) < MAX_LOCALS);
  end

  // the later output slot wins, so its bank is the one to read back
  always_comb begin
    vld_d = vld_q;
    sel_d = sel_q;
    if (acc && fof) begin
      vld_d = '0;
    end
    for (int k = 0; k < MAX_DST; k++) begin
      if (wr_en[k]) begin
        vld_d[wr_addr[k]] = 1'b1;
        sel_d[wr_addr[k]] = (k != 0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      vld_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      vld_q <= vld_d;
      if (adv) begin
        v1_q        <= acc;
        v2_q        <= v1_q;
        out_valid_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
    if (adv) begin
      ovf1_q  <= ovf0;
      idx1_q  <= idx0;
      ovf2_q  <= ovf1_q;
      idx2_q  <= idx1_q;
      ovf_q   <= ovf2_q;
      idx_q   <= ovf2_q ? '0 : idx2_q;
      level_q <= ovf2_q ? '0 : level_m;
      row_q   <= ovf2_q ? '0 : row_m;
    end
  end

  assign fwd_en = v2_q && !ovf2_q;
  assign dep_we = adv && fwd_en;

  for (genvar l = 0; l < MAX_SRC; l++) begin : g_lane
    lane_ctl_t     ctl;
    logic [LW-1:0] addr;

    assign addr        = LW'(src[l]);
    assign ctl.adv     = adv;
    assign ctl.src_ok  = live && !fof && in_i.src_valid[l] &&
                         (32'(src[l]) < MAX_LOCALS) && vld_q[addr];
    assign ctl.src_sel = sel_q[addr];
    assign ctl.fwd_en  = fwd_en;
    assign ctl.dep_we  = dep_we;

    ddr_lane #(
      .MAX_INSTR  (MAX_INSTR),
      .MAX_LOCALS (MAX_LOCALS),
      .MAX_DST    (MAX_DST)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .src_addr_i (addr),
      .wr_en_i    (wr_en),
      .wr_addr_i  (wr_addr),
      .wr_idx_i   (idx0),
      .dep_addr_i (idx2_q),
      .dep_row_i  (row_m),
      .dep_rank_i (level_m),
      .fwd_idx_i  (idx2_q),
      .fwd_row_i  (row_q),
      .fwd_rank_i (level_q),
      .row_o      (lane_row[l]),
      .rank_o     (lane_rank[l])
    );
  end

  ddr_merge #(
    .MAX_INSTR (MAX_INSTR),
    .MAX_SRC   (MAX_SRC)
  ) u_merge (
    .row_i   (lane_row),
    .rank_i  (lane_rank),
    .row_o   (row_m),
    .level_o (level_m)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.instr_index = INDEX_W'(idx_q);
  assign out_o.level       = level_q;
  assign out_o.depends_on  = DEP_W'(row_q);
  assign out_o.overflow    = ovf_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_INSTR))
    else $error("instruction counter beyond capacity");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live |=> cnt_q == CW'($past(base) + CW'(1)))
    else $error("counter did not advance on an accepted instruction");

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.overflow |->
      out_o.level == '0 && out_o.depends_on == '0 && out_o.instr_index == '0)
    else $error("overflow beat carries nonzero fields");

  a_level_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.overflow |-> out_o.level != '0)
    else $error("ranked instruction with level zero");

endmodule
